### rtl/core/fcsg_pkg.sv
// Package for the filled circle span generator.
// Holds field widths, mode codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package fcsg_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 11;

    localparam int CENTER_W = 15;
    localparam int DIAM_W   = 12;
    localparam int OUT_W    = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam int QUEUE_DEPTH = 2;

    localparam int SPAN_IDX_W = 2;
    localparam logic [SPAN_IDX_W-1:0] SPAN_FIRST  = 2'd0;
    localparam logic [SPAN_IDX_W-1:0] SPAN_SECOND = 2'd1;
    localparam logic [SPAN_IDX_W-1:0] SPAN_THIRD  = 2'd2;
    localparam logic [SPAN_IDX_W-1:0] SPAN_LAST   = 2'd3;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

endpackage

### rtl/core/fcsg_queue.sv
// Small register queue between the front and back of the span generator.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module fcsg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

endmodule

### rtl/core/fcsg_front.sv
// Front of the span generator: takes input words, keeps the midpoint state
// and queues one job per step. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_front #(
    parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF,
    parameter int JOB_W       = 2 * fcsg_pkg::CENTER_W + 2 * RADIUS_BITS + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              mode,
    input  logic signed [fcsg_pkg::CENTER_W-1:0] center_x,
    input  logic signed [fcsg_pkg::CENTER_W-1:0] center_y,
    input  logic [fcsg_pkg::DIAM_W-1:0]       diameter,
    output logic                              push,
    output logic [JOB_W-1:0]                  job_data
);

    localparam int OW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 4;

    logic signed [fcsg_pkg::CENTER_W-1:0] cx_reg, cx_next;
    logic signed [fcsg_pkg::CENTER_W-1:0] cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]               r_reg, r_next;
    logic signed [OW-1:0]                 ox_reg, ox_next;
    logic signed [OW-1:0]                 oy_reg, oy_next;
    logic signed [DW-1:0]                 dec_reg, dec_next;
    logic                                 drawing_reg, drawing_next;

    logic [fcsg_pkg::DIAM_W-2:0] half;
    logic [RADIUS_BITS-1:0]      r_start;
    logic signed [DW-1:0]        oxd, oyd, rd, two_ox, lim;
    logic signed [OW-1:0]        ox_inc, oy_dec;
    logic signed [OW-1:0]        ox_upd, oy_upd;
    logic signed [DW-1:0]        dec_upd;
    logic                        step_done;

    assign half    = diameter[fcsg_pkg::DIAM_W-1:1];
    assign r_start = RADIUS_BITS'(half);

    assign oxd    = DW'(ox_reg);
    assign oyd    = DW'(oy_reg);
    assign rd     = DW'({1'b0, r_reg});
    assign two_ox = oxd <<< 1;
    assign lim    = (rd - oyd) <<< 1;
    assign ox_inc = ox_reg + OW'(1);
    assign oy_dec = oy_reg - OW'(1);

    // three-way midpoint decision
    always_comb
    begin
        priority if (dec_reg >= two_ox)
        begin
            dec_upd = dec_reg - (two_ox + DW'(1));
            ox_upd  = ox_inc;
            oy_upd  = oy_reg;
        end
        else if (dec_reg < lim)
        begin
            dec_upd = dec_reg + ((oyd <<< 1) - DW'(1));
            ox_upd  = ox_reg;
            oy_upd  = oy_dec;
        end
        else
        begin
            dec_upd = dec_reg + ((oyd - oxd - DW'(1)) <<< 1);
            ox_upd  = ox_inc;
            oy_upd  = oy_dec;
        end
    end

    assign step_done = (oy_upd < ox_upd);

    assign push     = accept && (mode == fcsg_pkg::MODE_STEP) && drawing_reg;
    assign job_data = {step_done, cy_reg, cx_reg,
                       oy_reg[RADIUS_BITS-1:0], ox_reg[RADIUS_BITS-1:0]};

    always_comb
    begin
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        r_next       = r_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        dec_next     = dec_reg;
        drawing_next = drawing_reg;
        if (accept)
        begin
            if (mode == fcsg_pkg::MODE_START)
            begin
                cx_next      = center_x;
                cy_next      = center_y;
                r_next       = r_start;
                ox_next      = '0;
                oy_next      = OW'(r_start);
                dec_next     = DW'(r_start) - DW'(1);
                drawing_next = 1'b1;
            end
            else if (drawing_reg)
            begin
                ox_next      = ox_upd;
                oy_next      = oy_upd;
                dec_next     = dec_upd;
                drawing_next = !step_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            r_reg       <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            dec_reg     <= '0;
            drawing_reg <= 1'b0;
        end
        else
        begin
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            r_reg       <= r_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            dec_reg     <= dec_next;
            drawing_reg <= drawing_next;
        end
    end

endmodule

### rtl/core/fcsg_back.sv
// Back of the span generator: expands each queued job into four spans,
// one per cycle unless the output is stalled, through an output register. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_back #(
    parameter int COORD_BITS  = fcsg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF,
    parameter int JOB_W       = 2 * fcsg_pkg::CENTER_W + 2 * RADIUS_BITS + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [JOB_W-1:0]                    q_data,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fcsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser
);

    localparam int CW = fcsg_pkg::CENTER_W;
    localparam int RB = RADIUS_BITS;

    logic [JOB_W-1:0]               job_reg, job_next;
    logic                           job_valid_reg, job_valid_next;
    logic [fcsg_pkg::SPAN_IDX_W-1:0] idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [fcsg_pkg::OUT_TDATA_W-1:0] data_reg, data_next;
    logic                           last_reg, last_next;
    logic                           done_reg, done_next;

    logic [RB-1:0]          ox, oy;
    logic signed [CW-1:0]   cx, cy;
    logic                   job_done;
    logic [COORD_BITS-1:0]  cxc, cyc, a_off, b_off;
    logic [COORD_BITS-1:0]  left_x, right_x, row;
    logic                   advance, at_last, neg_row, use_oy;

    assign ox       = job_reg[RB-1:0];
    assign oy       = job_reg[2*RB-1:RB];
    assign cx       = job_reg[2*RB+CW-1:2*RB];
    assign cy       = job_reg[2*RB+2*CW-1:2*RB+CW];
    assign job_done = job_reg[JOB_W-1];

    assign cxc = COORD_BITS'(cx);
    assign cyc = COORD_BITS'(cy);

    // first and last spans run x +- oy on rows y +- ox; middle two swap
    always_comb
    begin
        unique case (idx_reg)
            fcsg_pkg::SPAN_FIRST:  begin use_oy = 1'b1; neg_row = 1'b0; end
            fcsg_pkg::SPAN_SECOND: begin use_oy = 1'b0; neg_row = 1'b0; end
            fcsg_pkg::SPAN_THIRD:  begin use_oy = 1'b0; neg_row = 1'b1; end
            fcsg_pkg::SPAN_LAST:   begin use_oy = 1'b1; neg_row = 1'b1; end
            default:               begin use_oy = 1'b0; neg_row = 1'b0; end
        endcase
    end

    assign a_off   = use_oy ? COORD_BITS'(oy) : COORD_BITS'(ox);
    assign b_off   = use_oy ? COORD_BITS'(ox) : COORD_BITS'(oy);
    assign left_x  = cxc - a_off;
    assign right_x = cxc + a_off;
    assign row     = neg_row ? (cyc - b_off) : (cyc + b_off);

    assign at_last = (idx_reg == fcsg_pkg::SPAN_LAST);
    assign advance = job_valid_reg && (!out_valid_reg || m_axis_tready);
    assign q_pop   = q_valid && (!job_valid_reg || (advance && at_last));

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (advance)
        begin
            idx_next       = idx_reg + fcsg_pkg::SPAN_IDX_W'(1);
            out_valid_next = 1'b1;
            data_next      = {fcsg_pkg::OUT_W'(32'(row)),
                              fcsg_pkg::OUT_W'(32'(right_x)),
                              fcsg_pkg::OUT_W'(32'(left_x))};
            last_next      = at_last;
            done_next      = at_last && job_done;
            if (at_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            job_next       = q_data;
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= fcsg_pkg::SPAN_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        data_reg <= data_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = data_reg;
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = done_reg;

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> (idx_reg == fcsg_pkg::SPAN_FIRST))
        else $error("span index not at first span while no job is held");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("circle done flagged on a span that is not the last of its step");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

endmodule

### rtl/core/filled_circle_span_generator.sv
// Top level of the filled circle span generator (midpoint, filled spans).
// Depends on fcsg_pkg, fcsg_front, fcsg_queue and fcsg_back.
//
//  channel   dir  tdata                                    tuser          tlast
//  s_axis    in   center_x[14:0] center_y[29:15]           mode           -
//                 diameter[41:30], zero pad to 48
//  m_axis    out  span_left_x[15:0] span_right_x[31:16]    circle_done    last_of_step
//                 span_row[47:32]
//
// A start word gives no output; a step word while drawing gives four spans,
// one per cycle while the output is not stalled, from the single output port
// of the span expander.
// Input words are taken while the two-entry job queue has room; the front
// keeps running while the output is stalled until that queue fills.
// Reset clears the circle state to idle; no clearing pass is needed.
`timescale 1ns / 1ps

module filled_circle_span_generator #(
    parameter int COORD_BITS  = fcsg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fcsg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // center_x, center_y, diameter
    input  logic [0:0]                          s_axis_tuser,  // mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fcsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // span_left_x, span_right_x, span_row
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser   // circle_done
);

    localparam int CW    = fcsg_pkg::CENTER_W;
    localparam int JOB_W = 2 * CW + 2 * RADIUS_BITS + 1;

    logic             accept;
    logic             push, pop, q_full, q_empty;
    logic [JOB_W-1:0] push_data, pop_data;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fcsg_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (s_axis_tuser[0]),
        .center_x (s_axis_tdata[CW-1:0]),
        .center_y (s_axis_tdata[2*CW-1:CW]),
        .diameter (s_axis_tdata[2*CW+fcsg_pkg::DIAM_W-1:2*CW]),
        .push     (push),
        .job_data (push_data)
    );

    fcsg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (fcsg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (pop_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    fcsg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (!q_empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### bench/fcsg_span_checker.sv
// Span checker for the filled circle span generator: watches both stream channels,
// predicts the spans of every accepted word and compares them. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_span_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [fcsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [fcsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic [0:0]                        m_axis_tuser,
    output int                                mismatches,
    output int                                pending,
    output logic                              circle_open
);

    localparam int OUT_W    = fcsg_pkg::OUT_W;
    localparam int CENTER_W = fcsg_pkg::CENTER_W;
    localparam int DIAM_W   = fcsg_pkg::DIAM_W;

    typedef struct packed {
        logic [OUT_W-1:0] left_x;
        logic [OUT_W-1:0] right_x;
        logic [OUT_W-1:0] row;
        logic             last_of_step;
        logic             circle_done;
    } span_t;

    logic signed [CENTER_W-1:0]                  centre_col;
    logic signed [CENTER_W-1:0]                  centre_row;
    logic        [fcsg_pkg::RADIUS_BITS_DEF-1:0] radius;
    logic        [11:0]                          ox_reg;
    logic        [11:0]                          oy_reg;
    logic signed [13:0]                          decision;
    span_t                                       spans_due[$];

    task automatic report_error(input string msg);
        mismatches++;
        $display("%0t ns: span mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic push_span(input int left, input int right, input int row,
                             input bit last, input bit done);
        span_t s;
        s.left_x       = left[OUT_W-1:0];
        s.right_x      = right[OUT_W-1:0];
        s.row          = row[OUT_W-1:0];
        s.last_of_step = last;
        s.circle_done  = done;
        spans_due.push_back(s);
    endtask

    // midpoint iteration: the three-way decision update, and four spans from the offsets before it
    task automatic rasterize(input logic mode,
                             input logic [fcsg_pkg::IN_TDATA_W-1:0] word);
        int ox;
        int oy;
        int cx;
        int cy;
        int d;
        int nox;
        int noy;
        bit done;
        if (mode == fcsg_pkg::MODE_START)
        begin
            centre_col  = word[CENTER_W-1:0];
            centre_row  = word[2*CENTER_W-1:CENTER_W];
            radius      = word[2*CENTER_W+DIAM_W-1:2*CENTER_W+1];
            ox_reg      = '0;
            oy_reg      = 12'(radius);
            decision    = 14'(int'(radius) - 1);
            circle_open = 1'b1;
        end
        else if (circle_open)
        begin
            ox  = ox_reg;
            oy  = oy_reg;
            cx  = centre_col;
            cy  = centre_row;
            d   = decision;
            nox = ox;
            noy = oy;
            if (d >= 2 * ox)
            begin
                d   = d - (2 * ox + 1);
                nox = ox + 1;
            end
            else if (d < 2 * (int'(radius) - oy))
            begin
                d   = d + 2 * oy - 1;
                noy = oy - 1;
            end
            else
            begin
                d   = d + 2 * (oy - ox - 1);
                noy = oy - 1;
                nox = ox + 1;
            end
            done     = noy < nox;
            ox_reg   = nox[11:0];
            oy_reg   = noy[11:0];
            decision = d[13:0];
            if (done)
            begin
                circle_open = 1'b0;
            end
            push_span(cx - oy, cx + oy, cy + ox, 1'b0, 1'b0);
            push_span(cx - ox, cx + ox, cy + oy, 1'b0, 1'b0);
            push_span(cx - ox, cx + ox, cy - oy, 1'b0, 1'b0);
            push_span(cx - oy, cx + oy, cy - ox, 1'b1, done);
        end
    endtask

    task automatic check_span();
        span_t want;
        if (spans_due.size() == 0)
        begin
            report_error($sformatf("unexpected word %h", m_axis_tdata));
        end
        else
        begin
            want = spans_due.pop_front();
            check_field("span_left_x", m_axis_tdata[OUT_W-1:0], want.left_x);
            check_field("span_right_x", m_axis_tdata[2*OUT_W-1:OUT_W], want.right_x);
            check_field("span_row", m_axis_tdata[3*OUT_W-1:2*OUT_W], want.row);
            check_field("last_of_step", 16'(m_axis_tlast), 16'(want.last_of_step));
            check_field("circle_done", 16'(m_axis_tuser[0]), 16'(want.circle_done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_col  = '0;
            centre_row  = '0;
            radius      = '0;
            ox_reg      = '0;
            oy_reg      = '0;
            decision    = '0;
            circle_open = 1'b0;
            spans_due.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_span();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rasterize(s_axis_tuser[0], s_axis_tdata);
            end
            pending = spans_due.size();
        end
    end

endmodule

### bench/tb_filled_circle_span_generator.sv
// Testbench top for the filled circle span generator: drives start and step words,
// random handshake gaps and back-pressure. Depends on fcsg_pkg and fcsg_span_checker.
`timescale 1ns / 1ps

module tb_filled_circle_span_generator;

    localparam int FULL_CIRCLE = 1 << 30;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int WORD_TARGET = 180;
    localparam int CENTER_W    = fcsg_pkg::CENTER_W;
    localparam int DIAM_W      = fcsg_pkg::DIAM_W;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [fcsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // center_x, center_y, diameter, zero pad
    logic [0:0]                        s_axis_tuser;   // mode
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [fcsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // span_left_x, span_right_x, span_row
    logic                              m_axis_tlast;
    logic [0:0]                        m_axis_tuser;   // circle_done

    int   mismatches;
    int   pending;
    logic circle_open;
    int   work_words;
    bit   tx_steady;
    bit   rx_steady;
    bit   hold_req;

    filled_circle_span_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    fcsg_span_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending),
        .circle_open   (circle_open)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic mode, input logic [CENTER_W-1:0] cx,
                             input logic [CENTER_W-1:0] cy, input logic [DIAM_W-1:0] diam);
        int gap;
        gap = pick_wait(tx_steady);
        if (mode == fcsg_pkg::MODE_START || circle_open)
        begin
            work_words++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {6'b0, diam, cy, cx};
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic draw_circle(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                               input logic [DIAM_W-1:0] diam, input int max_steps);
        int n;
        n = 0;
        send_word(fcsg_pkg::MODE_START, cx, cy, diam);
        while (circle_open && n < max_steps)
        begin
            send_word(fcsg_pkg::MODE_STEP, 15'($urandom), 15'($urandom), 12'($urandom));
            n++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // result side: per-word stall, occasional long hold-off
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = pick_wait(rx_steady);
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            if ($urandom_range(0, 31) == 0)
            begin
                rx_steady = !rx_steady;
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("filled_circle_span_generator regression: fail");
        $finish;
    end

    initial
    begin
        int pick;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = fcsg_pkg::MODE_START;
        rst_n         = 1'b0;
        work_words    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // step while idle, zero radius, centre extremes, largest sizes abandoned
        send_word(fcsg_pkg::MODE_STEP, '0, '0, '0);
        draw_circle('0, '0, '0, 1);
        send_word(fcsg_pkg::MODE_STEP, '0, '0, '0);
        draw_circle(15'h3FFF, 15'h4000, 12'd1, 1);
        draw_circle(15'h4000, 15'h3FFF, 12'hFFF, 3);
        draw_circle(15'h3FFF, 15'h3FFF, 12'hFFE, 2);
        draw_circle(15'h4000, 15'h4000, 12'd2, FULL_CIRCLE);
        draw_circle(15'd5, 15'h7FF9, 12'd7, FULL_CIRCLE);
        send_word(fcsg_pkg::MODE_STEP, 15'h7FFF, 15'h7FFF, 12'hFFF);
        drain();

        // fill the block against a held output
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        draw_circle(15'd100, 15'h7F9C, 12'd40, FULL_CIRCLE);
        tx_steady = 1'b0;

        while (work_words < WORD_TARGET)
        begin
            tx_steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                send_word(fcsg_pkg::MODE_STEP, 15'($urandom), 15'($urandom),
                          12'($urandom));
            end
            else if (pick == 1)
            begin
                send_word(fcsg_pkg::MODE_START, 15'($urandom), 15'($urandom),
                          12'($urandom));
            end
            else if (pick == 2)
            begin
                draw_circle(15'($urandom), 15'($urandom), 12'($urandom),
                            $urandom_range(1, 4));
            end
            else if (pick < 6)
            begin
                draw_circle(15'($urandom), 15'($urandom), 12'($urandom_range(0, 48)),
                            $urandom_range(0, 6));
            end
            else
            begin
                draw_circle(15'($urandom), 15'($urandom), 12'($urandom_range(0, 48)),
                            FULL_CIRCLE);
            end
        end
        drain();

        if (mismatches == 0 && pending == 0)
        begin
            $display("filled_circle_span_generator regression: pass");
        end
        else
        begin
            $display("filled_circle_span_generator regression: fail");
        end
        $finish;
    end

endmodule
